// ===== rtl/dds_pkg.sv =====
// shared constants, sine table contents and helpers for the dds sine generator
package dds_pkg;

  localparam int PHASE_W    = 24;
  localparam int FREQ_W     = 27;
  localparam int SAMPLE_W   = 8;
  localparam int TABLE_SIZE = 256;
  localparam int TABLE_AW   = $clog2(TABLE_SIZE);

  localparam logic [SAMPLE_W-1:0] MIDSCALE = 8'd127;

  // word = (f * 838860800 + 5e9) / 1e10 reduces exactly to
  // (f * 2^16 + 390625) / 781250
  localparam int TUNE_SHIFT = 16;
  localparam int TUNE_BIAS  = 390625;
  localparam int TUNE_DIV   = 781250;
  // one spare top bit, the bias can carry out of f * 2^16
  localparam int DIVIDEND_W = FREQ_W + TUNE_SHIFT + 1;

  // quotient estimate from the top bits of the dividend times floor(2^46 / 781250),
  // never above the true quotient and at most one below it
  localparam int RECIP_LSB   = 12;
  localparam int RECIP_IN_W  = DIVIDEND_W - RECIP_LSB;
  localparam int TUNE_RECIP  = 90071992;
  localparam int RECIP_W     = 27;
  localparam int RECIP_SHIFT = 34;
  localparam int PROD_W      = RECIP_IN_W + RECIP_W;
  localparam int QUOT_W      = PROD_W - RECIP_SHIFT;

  localparam logic [SAMPLE_W-1:0] SINE_ROM [TABLE_SIZE] = '{
    8'd127, 8'd130, 8'd133, 8'd136, 8'd139, 8'd143, 8'd146, 8'd149,
    8'd152, 8'd155, 8'd158, 8'd161, 8'd164, 8'd167, 8'd170, 8'd173,
    8'd176, 8'd179, 8'd182, 8'd184, 8'd187, 8'd190, 8'd193, 8'd195,
    8'd198, 8'd200, 8'd203, 8'd205, 8'd208, 8'd210, 8'd213, 8'd215,
    8'd217, 8'd219, 8'd221, 8'd224, 8'd226, 8'd228, 8'd229, 8'd231,
    8'd233, 8'd235, 8'd236, 8'd238, 8'd239, 8'd241, 8'd242, 8'd244,
    8'd245, 8'd246, 8'd247, 8'd248, 8'd249, 8'd250, 8'd251, 8'd251,
    8'd252, 8'd253, 8'd253, 8'd254, 8'd254, 8'd254, 8'd254, 8'd254,
    8'd255, 8'd254, 8'd254, 8'd254, 8'd254, 8'd254, 8'd253, 8'd253,
    8'd252, 8'd251, 8'd251, 8'd250, 8'd249, 8'd248, 8'd247, 8'd246,
    8'd245, 8'd244, 8'd242, 8'd241, 8'd239, 8'd238, 8'd236, 8'd235,
    8'd233, 8'd231, 8'd229, 8'd228, 8'd226, 8'd224, 8'd221, 8'd219,
    8'd217, 8'd215, 8'd213, 8'd210, 8'd208, 8'd205, 8'd203, 8'd200,
    8'd198, 8'd195, 8'd193, 8'd190, 8'd187, 8'd184, 8'd182, 8'd179,
    8'd176, 8'd173, 8'd170, 8'd167, 8'd164, 8'd161, 8'd158, 8'd155,
    8'd152, 8'd149, 8'd146, 8'd143, 8'd139, 8'd136, 8'd133, 8'd130,
    8'd127, 8'd124, 8'd121, 8'd118, 8'd115, 8'd111, 8'd108, 8'd105,
    8'd102, 8'd99,  8'd96,  8'd93,  8'd90,  8'd87,  8'd84,  8'd81,
    8'd78,  8'd75,  8'd72,  8'd70,  8'd67,  8'd64,  8'd61,  8'd59,
    8'd56,  8'd54,  8'd51,  8'd49,  8'd46,  8'd44,  8'd41,  8'd39,
    8'd37,  8'd35,  8'd33,  8'd30,  8'd28,  8'd26,  8'd25,  8'd23,
    8'd21,  8'd19,  8'd18,  8'd16,  8'd15,  8'd13,  8'd12,  8'd10,
    8'd9,   8'd8,   8'd7,   8'd6,   8'd5,   8'd4,   8'd3,   8'd3,
    8'd2,   8'd1,   8'd1,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
    8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd1,   8'd1,
    8'd2,   8'd3,   8'd3,   8'd4,   8'd5,   8'd6,   8'd7,   8'd8,
    8'd9,   8'd10,  8'd12,  8'd13,  8'd15,  8'd16,  8'd18,  8'd19,
    8'd21,  8'd23,  8'd25,  8'd26,  8'd28,  8'd30,  8'd33,  8'd35,
    8'd37,  8'd39,  8'd41,  8'd44,  8'd46,  8'd49,  8'd51,  8'd54,
    8'd56,  8'd59,  8'd61,  8'd64,  8'd67,  8'd70,  8'd72,  8'd75,
    8'd78,  8'd81,  8'd84,  8'd87,  8'd90,  8'd93,  8'd96,  8'd99,
    8'd102, 8'd105, 8'd108, 8'd111, 8'd115, 8'd118, 8'd121, 8'd124
  };

  function automatic logic [SAMPLE_W-1:0] sine_lut(input logic [TABLE_AW-1:0] idx);
    return SINE_ROM[idx];
  endfunction

endpackage

// ===== rtl/dds_ram.sv =====
// generic single write port, single read port ram with registered read data
module dds_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/dds_tune_div.sv =====
// tuning word unit: rounds the frequency into a phase increment by reciprocal multiplication
module dds_tune_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [dds_pkg::FREQ_W-1:0]   freq,
  output logic                         busy,
  output logic [dds_pkg::PHASE_W-1:0]  word
);

  import dds_pkg::*;

  logic [2:0]            stage_r,  stage_nxt;
  logic [DIVIDEND_W-1:0] dividend;
  logic [DIVIDEND_W-1:0] num_r;
  logic [PROD_W-1:0]     prod_r,   prod_nxt;
  logic [QUOT_W-1:0]     qest_r,   qest_nxt;
  logic [DIVIDEND_W-1:0] qprod_r,  qprod_nxt;
  logic [DIVIDEND_W-1:0] rem;
  logic [PHASE_W-1:0]    word_r,   word_nxt;

  assign dividend  = {1'b0, freq, TUNE_SHIFT'(0)} + DIVIDEND_W'(TUNE_BIAS);
  assign stage_nxt = {stage_r[1:0], start};

  // estimate, then one correction step on the remainder
  assign prod_nxt  = PROD_W'(num_r[DIVIDEND_W-1 -: RECIP_IN_W]) * PROD_W'(TUNE_RECIP);
  assign qest_nxt  = prod_r[PROD_W-1 -: QUOT_W];
  assign qprod_nxt = DIVIDEND_W'(qest_nxt) * DIVIDEND_W'(TUNE_DIV);
  assign rem       = num_r - qprod_r;
  assign word_nxt  = PHASE_W'(qest_r) + PHASE_W'(rem >= DIVIDEND_W'(TUNE_DIV));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r <= '0;
      word_r  <= '0;
    end else begin
      stage_r <= stage_nxt;
      if (stage_r[2]) begin
        word_r <= word_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= dividend;
    end
    if (stage_r[0]) begin
      prod_r <= prod_nxt;
    end
    if (stage_r[1]) begin
      qest_r  <= qest_nxt;
      qprod_r <= qprod_nxt;
    end
  end

  assign busy = |stage_r;
  assign word = word_r;

endmodule

// ===== rtl/dds_sine_generator.sv =====
// dds sine generator top level: phase accumulator, sine table ram and output pipeline
//
// input channel (in_valid / in_stall) carries one sample tick request: enable and
// restart. each accepted request yields exactly one result on the output channel
// (out_valid / out_stall): the sine sample and the phase after the tick.
// a request accepted passes through the table read stage (the registered ram read)
// and then the output register before the receiver can take it.
// throughput: one request per cycle while no table load, tuning word computation or
// output stall holds it, set by the phase add and one sine ram read per cycle.
// the configuration channel (cfg_valid / cfg_ready / cfg_data) writes the
// frequency in hundredths of a hertz; the tuning word is then worked out by a
// reciprocal multiply, during which cfg_ready is low and in_stall high.
// after reset the sine ram is loaded from the constant table, one entry a cycle,
// so in_stall stays high until all 256 entries are written; the phase and the tuning word reset to 0.
// when the receiver stalls, the result is held in the output register and one
// more request can still be taken into the table read stage; after that
// in_stall rises until the output drains.
module dds_sine_generator (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_enable,
  input  logic                          in_restart,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [dds_pkg::SAMPLE_W-1:0]  out_sample,
  output logic [dds_pkg::PHASE_W-1:0]   out_phase_out,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [dds_pkg::FREQ_W-1:0]    cfg_data
);

  import dds_pkg::*;

  localparam int FILL_W = TABLE_AW + 1;

  logic [FILL_W-1:0]   fill_cnt_r;
  logic                fill_busy;
  logic                div_busy;
  logic [PHASE_W-1:0]  tune_word;
  logic                cfg_write;

  logic [PHASE_W-1:0]  phase_r,   phase_nxt;
  logic [PHASE_W-1:0]  phase_base;
  logic                in_accept;

  logic                s1_valid_r;
  logic                s1_en_r;
  logic [PHASE_W-1:0]  s1_phase_r;
  logic                s1_adv;
  logic [SAMPLE_W-1:0] table_rdata;

  logic                out_valid_r;
  logic [SAMPLE_W-1:0] out_sample_r;
  logic [PHASE_W-1:0]  out_phase_r;

  // table load after reset
  assign fill_busy = ~fill_cnt_r[TABLE_AW];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_cnt_r <= '0;
    end else if (fill_busy) begin
      fill_cnt_r <= fill_cnt_r + 1'b1;
    end
  end

  assign cfg_ready = ~div_busy;
  assign cfg_write = cfg_valid & cfg_ready;

  dds_tune_div u_tune_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cfg_write),
    .freq  (cfg_data),
    .busy  (div_busy),
    .word  (tune_word)
  );

  // pipeline flow
  assign s1_adv    = s1_valid_r & (~out_valid_r | ~out_stall);
  assign in_stall  = fill_busy | div_busy | cfg_write | (s1_valid_r & ~s1_adv);
  assign in_accept = in_valid & ~in_stall;

  assign phase_base = in_restart ? '0 : phase_r;
  assign phase_nxt  = in_enable ? phase_base + tune_word : phase_base;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= '0;
    end else if (in_accept) begin
      phase_r <= phase_nxt;
    end
  end

  dds_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (TABLE_SIZE)
  ) u_sine_ram (
    .clk   (clk),
    .we    (fill_busy),
    .waddr (fill_cnt_r[TABLE_AW-1:0]),
    .wdata (sine_lut(fill_cnt_r[TABLE_AW-1:0])),
    .re    (in_accept),
    .raddr (phase_nxt[PHASE_W-1 -: TABLE_AW]),
    .rdata (table_rdata)
  );

  // table read stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_accept) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_en_r    <= in_enable;
      s1_phase_r <= phase_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (~out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_sample_r <= s1_en_r ? table_rdata : MIDSCALE;
      out_phase_r  <= s1_phase_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_sample    = out_sample_r;
  assign out_phase_out = out_phase_r;

  // checks
  a_no_accept_during_fill: assert property (@(posedge clk) disable iff (!rst_n)
    fill_busy |-> !in_accept)
    else $error("request accepted while sine table is loading");

  a_cfg_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_write |=> in_stall && !cfg_ready)
    else $error("input not held off while tuning word is computed");

  a_disabled_midscale: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && !s1_en_r) |=> out_sample == MIDSCALE)
    else $error("disabled tick did not give midscale");

  a_full_pipe_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && out_valid_r && out_stall) |-> in_stall)
    else $error("request taken with both stages full and output stalled");

endmodule
